FILE: rtl/core/assert_macros.svh
// assertion macros shared by the frame checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/core/crc8fc_pkg.sv
// types, constants and crc helper for the crc-8 frame checker
package crc8fc_pkg;

	// payload store depth default
	localparam int MAX_PAYLOAD_DEF = 8;

	// crc-8, msb first, no final xor
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// frame layout: start, id, seq, len, payload, crc, end
	localparam logic [8:0] HDR_BYTES      = 9'd4;
	localparam logic [9:0] FRAME_OVERHEAD = 10'd6;
	localparam logic [8:0] COUNT_MAX      = 9'd511;

	// byte positions in the frame
	localparam logic [8:0] POS_START = 9'd0;
	localparam logic [8:0] POS_ID    = 9'd1;
	localparam logic [8:0] POS_SEQ   = 9'd2;
	localparam logic [8:0] POS_LEN   = 9'd3;

	// register reset values
	localparam logic [7:0] START_MARKER_RST = 8'hAA;
	localparam logic [7:0] END_MARKER_RST   = 8'h55;
	localparam logic [3:0] MAX_LEN_RST      = 4'd8;

	// configuration register indexes
	localparam logic [1:0] REG_START_MARKER = 2'd0;
	localparam logic [1:0] REG_END_MARKER   = 2'd1;
	localparam logic [1:0] REG_MAX_LEN      = 2'd2;

	// result kinds
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// status error codes, first failing check wins
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_START     = 3'd2,
		ERR_END       = 3'd3,
		ERR_TOO_LONG  = 3'd4,
		ERR_LEN_MISM  = 3'd5,
		ERR_CRC       = 3'd6
	} err_code_t;

	// payload read-out sequencer
	typedef enum logic {
		DR_IDLE,
		DR_PAY
	} drain_state_t;

	// one byte through the crc, eight shift steps
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/crc8_frame_checker.sv
// crc-8 delimited frame checker with payload store and status/payload read-out
//
// channel  dir  tdata                          tuser        tlast
// s_*      in   [7:0] rx_byte                  -            end_of_buffer
// m_*      out  ok,err,id,seq,len,crc,pb,pidx  result_kind  last_result
// cfg_*    in   plain write: cfg_we, cfg_index, cfg_wdata
//
// one byte is taken per cycle with s_tready high; crc, header and count update in
// the accept cycle. status follows in the cycle after the final byte; a valid frame
// then gives one payload item per cycle as m_tready allows, from the payload memory
// (one registered read port). payload bytes of the next frame wait while the memory
// is read out, and a final byte waits while the output register or the read-out is
// busy. arst_n clears all control state; the payload memory needs no clearing pass.
`include "assert_macros.svh"

module crc8_frame_checker
	import crc8fc_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] frame_ok, [3:1] error_code, [11:4] message_id, [19:12] sequence_number,
	// [27:20] declared_length, [35:28] received_check, [43:36] payload_byte,
	// [46:44] payload_index, [47] zero
	output logic [47:0] m_tdata,
	output logic        m_tuser,   // [0] result_kind
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [8:0] MAXP9 = 9'(MAX_PAYLOAD);
	localparam logic [7:0] MAXP8 = 8'(MAX_PAYLOAD);

	// configuration registers
	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic [3:0] max_len_q;

	// frame state
	logic [8:0] byte_count_q;
	logic [7:0] crc_q;
	logic [7:0] id_q;
	logic [7:0] seq_q;
	logic [7:0] len_q;
	logic [7:0] chk_q;
	logic       start_ok_q;

	// payload memory
	logic [7:0]    pay_mem [MAX_PAYLOAD];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] wr_addr;

	// read-out sequencer and output register
	drain_state_t  drain_q, drain_d;
	logic [CW-1:0] pay_cnt_q;
	logic [CW-1:0] pay_len_q;
	logic          out_valid_q;
	logic          kind_q;
	logic          ok_q;
	err_code_t     err_q;
	logic [7:0]    o_id_q, o_seq_q, o_len_q, o_chk_q;
	logic [7:0]    o_byte_q;
	logic [2:0]    o_idx_q;
	logic          o_last_q;

	// combinational frame update
	logic       in_acc;
	logic [8:0] crc_pos;
	logic [8:0] wr_off;
	logic       pay_pos;
	logic [7:0] nxt_crc, nxt_id, nxt_seq, nxt_len, nxt_chk;
	logic       nxt_start_ok;
	logic [7:0] limit;
	logic [9:0] total;
	err_code_t  err;
	logic       out_free;
	logic       status_load;
	logic       pay_adv;
	logic       pay_last;
	logic [CW-1:0] pay_cnt_inc;

	assign out_free    = !out_valid_q || m_tready;
	assign crc_pos     = {1'b0, len_q} + HDR_BYTES;
	assign wr_off      = byte_count_q - HDR_BYTES;
	assign pay_pos     = (byte_count_q >= HDR_BYTES) && (byte_count_q < crc_pos)
		&& (wr_off < MAXP9);
	assign wr_addr     = wr_off[AW-1:0];

	// input interlock: no payload write during read-out, final byte needs a free output
	assign s_tready = !(drain_q == DR_PAY && pay_pos)
		&& (!s_tlast || (drain_q == DR_IDLE && out_free));
	assign in_acc   = s_tvalid && s_tready;
	assign mem_we   = in_acc && pay_pos;

	// per-byte state update by frame position
	always_comb begin
		nxt_crc      = crc_q;
		nxt_id       = id_q;
		nxt_seq      = seq_q;
		nxt_len      = len_q;
		nxt_chk      = chk_q;
		nxt_start_ok = start_ok_q;
		priority if (byte_count_q == POS_START) begin
			nxt_start_ok = (s_tdata == start_marker_q);
		end else if (byte_count_q <= POS_LEN) begin
			if (byte_count_q == POS_ID) nxt_id = s_tdata;
			else if (byte_count_q == POS_SEQ) nxt_seq = s_tdata;
			else nxt_len = s_tdata;
			nxt_crc = crc8_step(crc_q, s_tdata);
		end else if (byte_count_q < crc_pos) begin
			nxt_crc = crc8_step(crc_q, s_tdata);
		end else if (byte_count_q == crc_pos) begin
			nxt_chk = s_tdata;
		end else begin
			nxt_crc = crc_q;
		end
	end

	// frame checks on the final byte
	assign limit = ({4'b0, max_len_q} > MAXP8) ? MAXP8 : {4'b0, max_len_q};
	assign total = {1'b0, byte_count_q} + 10'd1;

	always_comb begin
		priority if (total < FRAME_OVERHEAD) err = ERR_SHORT;
		else if (!nxt_start_ok) err = ERR_START;
		else if (s_tdata != end_marker_q) err = ERR_END;
		else if (nxt_len > limit) err = ERR_TOO_LONG;
		else if (total != ({2'b0, nxt_len} + FRAME_OVERHEAD)) err = ERR_LEN_MISM;
		else if (nxt_chk != nxt_crc) err = ERR_CRC;
		else err = ERR_NONE;
	end

	assign status_load = in_acc && s_tlast;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
			max_len_q      <= MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_wdata;
				REG_END_MARKER:   end_marker_q   <= cfg_wdata;
				REG_MAX_LEN:      max_len_q      <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// frame state registers, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q        <= CRC_INIT;
			id_q         <= '0;
			seq_q        <= '0;
			len_q        <= '0;
			chk_q        <= '0;
			start_ok_q   <= 1'b0;
		end else if (in_acc) begin
			if (s_tlast) begin
				byte_count_q <= '0;
				crc_q        <= CRC_INIT;
				id_q         <= '0;
				seq_q        <= '0;
				len_q        <= '0;
				chk_q        <= '0;
				start_ok_q   <= 1'b0;
			end else begin
				byte_count_q <= (byte_count_q < COUNT_MAX) ? byte_count_q + 9'd1 : byte_count_q;
				crc_q        <= nxt_crc;
				id_q         <= nxt_id;
				seq_q        <= nxt_seq;
				len_q        <= nxt_len;
				chk_q        <= nxt_chk;
				start_ok_q   <= nxt_start_ok;
			end
		end
	end

	// payload memory write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pay_mem[wr_addr] <= s_tdata;
		end
	end

	// payload memory read port, address runs one ahead of the item count
	always_ff @(posedge clk) begin
		rd_data_q <= pay_mem[rd_addr];
	end

	// read-out sequencer: next state
	assign pay_cnt_inc = pay_cnt_q + CW'(1);
	assign pay_last    = (pay_cnt_inc == pay_len_q);

	always_comb begin
		drain_d = drain_q;
		unique case (drain_q)
			DR_IDLE: if (status_load && err == ERR_NONE && nxt_len != 8'd0) drain_d = DR_PAY;
			DR_PAY:  if (out_free && pay_last) drain_d = DR_IDLE;
			default: drain_d = DR_IDLE;
		endcase
	end

	// read-out sequencer: outputs
	always_comb begin
		pay_adv = 1'b0;
		rd_addr = pay_cnt_q[AW-1:0];
		unique case (drain_q)
			DR_IDLE: begin
				if (status_load) rd_addr = '0;
			end
			DR_PAY: begin
				pay_adv = out_free;
				if (out_free) rd_addr = pay_last ? '0 : pay_cnt_inc[AW-1:0];
			end
			default: pay_adv = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= DR_IDLE;
			pay_cnt_q   <= '0;
			pay_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			drain_q <= drain_d;
			if (status_load) begin
				pay_cnt_q <= '0;
				pay_len_q <= CW'(nxt_len);
			end else if (pay_adv) begin
				pay_cnt_q <= pay_cnt_inc;
			end
			if (status_load || pay_adv) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (status_load) begin
			kind_q   <= KIND_STATUS;
			ok_q     <= (err == ERR_NONE);
			err_q    <= err;
			o_id_q   <= (err == ERR_NONE || err >= ERR_TOO_LONG) ? nxt_id : 8'd0;
			o_seq_q  <= (err == ERR_NONE || err >= ERR_TOO_LONG) ? nxt_seq : 8'd0;
			o_len_q  <= (err == ERR_NONE || err >= ERR_TOO_LONG) ? nxt_len : 8'd0;
			o_chk_q  <= (err == ERR_NONE || err == ERR_CRC) ? nxt_chk : 8'd0;
			o_byte_q <= '0;
			o_idx_q  <= '0;
			o_last_q <= (err != ERR_NONE) || (nxt_len == 8'd0);
		end else if (pay_adv) begin
			kind_q   <= KIND_PAYLOAD;
			ok_q     <= 1'b1;
			err_q    <= ERR_NONE;
			o_byte_q <= rd_data_q;
			o_idx_q  <= 3'(pay_cnt_q);
			o_last_q <= pay_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {1'b0, o_idx_q, o_byte_q, o_chk_q, o_len_q, o_seq_q, o_id_q, err_q, ok_q};

	// checks
	`ASSERT_NEVER(a_no_write_in_readout, clk, arst_n, mem_we && drain_q == DR_PAY,
		"payload write while the memory is read out")
	`ASSERT_NEVER(a_no_overwrite_out, clk, arst_n, (status_load || pay_adv) && out_valid_q && !m_tready,
		"output item overwritten before it was taken")
	`ASSERT_AT(a_cnt_in_range, clk, arst_n, (drain_q == DR_PAY) |-> (pay_cnt_q < pay_len_q),
		"read-out count beyond payload length")
	`ASSERT_AT(a_readout_after_ok, clk, arst_n, $rose(drain_q == DR_PAY) |-> (m_tvalid && ok_q && !kind_q),
		"read-out started without an ok status")

endmodule
